// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the formatter modules.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication or any other property, checked on every rising clock edge.
`define FSIF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// A condition that must never be true on a rising clock edge.
`define FSIF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define FSIF_ASSERT(lbl, prop, msg)
`define FSIF_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hdl/fsif_pkg.sv =====
// Types, character codes and helper functions for the integer formatter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package fsif_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_LOW_H   = 8'h68;
  localparam logic [7:0] CH_LOW_L   = 8'h6c;
  localparam logic [7:0] CH_LOW_C   = 8'h63;
  localparam logic [7:0] CH_LOW_D   = 8'h64;
  localparam logic [7:0] CH_LOW_I   = 8'h69;
  localparam logic [7:0] CH_LOW_U   = 8'h75;
  localparam logic [7:0] CH_LOW_X   = 8'h78;
  localparam logic [7:0] CH_UP_X    = 8'h58;
  localparam logic [7:0] CH_LOW_P   = 8'h70;
  localparam logic [7:0] CH_LOW_O   = 8'h6f;
  localparam logic [7:0] CH_LOW_B   = 8'h62;
  localparam logic [7:0] CH_UP_B    = 8'h42;

  // Width of the BCD register: 20 decimal digits cover any 64-bit value.
  localparam int unsigned BCD_W = 80;
  localparam int unsigned BCD_DIGITS = BCD_W / 4;

  // Depth of the command queue between the parser and the digit engine.
  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [0:0] {
    CMD_CHAR = 1'b0,
    CMD_NUM  = 1'b1
  } cmd_kind_e;

  typedef enum logic [1:0] {
    RAD_DEC = 2'd0,
    RAD_HEX = 2'd1,
    RAD_OCT = 2'd2,
    RAD_BIN = 2'd3
  } radix_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  ch;
    logic [63:0] mag;
    logic        neg;
    logic        wide;
    radix_e      radix;
  } cmd_t;

  // Lowercase hex digit character for a digit value.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'b0000, d};
    end else begin
      c = 8'h57 + {4'b0000, d};
    end
    return c;
  endfunction

endpackage

// ===== hdl/fsif_front.sv =====
// Format parser: tracks the conversion spec and turns each format character
// into an output command. Depends on fsif_pkg.
`timescale 1ns / 1ps

module fsif_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         fmt_char_i,
  input  logic [63:0]        arg_value_i,
  output logic               push_o,
  output fsif_pkg::cmd_t     cmd_o
);

  typedef enum logic [4:0] {
    PH_TEXT  = 5'b00001,
    PH_PCT   = 5'b00010,
    PH_H     = 5'b00100,
    PH_L     = 5'b01000,
    PH_FINAL = 5'b10000
  } phase_e;

  phase_e phase_q, phase_d;
  logic   wide_q, wide_d;
  logic   is_letter;
  logic   has_cmd;
  logic   sgn;
  logic   neg;
  logic [63:0] mag;
  logic [31:0] low_neg;

  // Magnitude and sign of the argument at the current length.
  always_comb begin
    low_neg = 32'd0 - arg_value_i[31:0];
    neg = 1'b0;
    mag = '0;
    if (wide_q) begin
      neg = sgn & arg_value_i[63];
      mag = neg ? (64'd0 - arg_value_i) : arg_value_i;
    end else begin
      neg = sgn & arg_value_i[31];
      mag = {32'd0, neg ? low_neg : arg_value_i[31:0]};
    end
  end

  always_comb begin
    phase_d   = phase_q;
    wide_d    = wide_q;
    is_letter = 1'b0;
    case (phase_q)
      PH_PCT: begin
        if (fmt_char_i == fsif_pkg::CH_LOW_H) begin
          phase_d = PH_H;
        end else if (fmt_char_i == fsif_pkg::CH_LOW_L) begin
          phase_d = PH_L;
        end else begin
          is_letter = 1'b1;
        end
      end
      PH_H: begin
        if (fmt_char_i == fsif_pkg::CH_LOW_H) begin
          phase_d = PH_FINAL;
        end else begin
          is_letter = 1'b1;
        end
      end
      PH_L: begin
        if (fmt_char_i == fsif_pkg::CH_LOW_L) begin
          phase_d = PH_FINAL;
          wide_d  = 1'b1;
        end else begin
          is_letter = 1'b1;
        end
      end
      PH_FINAL: begin
        is_letter = 1'b1;
      end
      default: begin
        if (fmt_char_i == fsif_pkg::CH_PERCENT) begin
          phase_d = PH_PCT;
          wide_d  = 1'b0;
        end else begin
          phase_d = PH_TEXT;
        end
      end
    endcase
    if (is_letter) begin
      phase_d = PH_TEXT;
      wide_d  = 1'b0;
    end
  end

  // Command built from the character.
  always_comb begin
    has_cmd     = 1'b0;
    sgn         = 1'b0;
    cmd_o.kind  = fsif_pkg::CMD_CHAR;
    cmd_o.ch    = fmt_char_i;
    cmd_o.radix = fsif_pkg::RAD_DEC;
    cmd_o.wide  = wide_q;
    if (!is_letter) begin
      has_cmd = (phase_q != PH_PCT) && (phase_q != PH_H) && (phase_q != PH_L)
                && (phase_q != PH_FINAL) && (fmt_char_i != fsif_pkg::CH_PERCENT);
    end else begin
      case (fmt_char_i)
        fsif_pkg::CH_LOW_C: begin
          has_cmd  = 1'b1;
          cmd_o.ch = arg_value_i[7:0];
        end
        fsif_pkg::CH_PERCENT: begin
          has_cmd  = 1'b1;
          cmd_o.ch = fsif_pkg::CH_PERCENT;
        end
        fsif_pkg::CH_LOW_D, fsif_pkg::CH_LOW_I: begin
          has_cmd    = 1'b1;
          sgn        = 1'b1;
          cmd_o.kind = fsif_pkg::CMD_NUM;
        end
        fsif_pkg::CH_LOW_U: begin
          has_cmd    = 1'b1;
          cmd_o.kind = fsif_pkg::CMD_NUM;
        end
        fsif_pkg::CH_LOW_X, fsif_pkg::CH_UP_X, fsif_pkg::CH_LOW_P: begin
          has_cmd     = 1'b1;
          cmd_o.kind  = fsif_pkg::CMD_NUM;
          cmd_o.radix = fsif_pkg::RAD_HEX;
        end
        fsif_pkg::CH_LOW_O: begin
          has_cmd     = 1'b1;
          cmd_o.kind  = fsif_pkg::CMD_NUM;
          cmd_o.radix = fsif_pkg::RAD_OCT;
        end
        fsif_pkg::CH_LOW_B, fsif_pkg::CH_UP_B: begin
          has_cmd     = 1'b1;
          cmd_o.kind  = fsif_pkg::CMD_NUM;
          cmd_o.radix = fsif_pkg::RAD_BIN;
        end
        default: begin
          has_cmd = 1'b0;
        end
      endcase
    end
    cmd_o.mag = mag;
    cmd_o.neg = neg;
  end

  assign push_o = accept_i & has_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TEXT;
      wide_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      wide_q  <= wide_d;
    end
  end

endmodule

// ===== hdl/fsif_fifo.sv =====
// Short command queue between the parser and the digit engine.
// Depends on fsif_pkg for the command type and depth.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fsif_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fsif_pkg::cmd_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output fsif_pkg::cmd_t  data_o
);

  localparam int unsigned PW = $clog2(fsif_pkg::FIFO_DEPTH);
  localparam int unsigned CW = $clog2(fsif_pkg::FIFO_DEPTH + 1);

  fsif_pkg::cmd_t entry_q [fsif_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o  = (count_q == CW'(fsif_pkg::FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] n;
    if (p == PW'(fsif_pkg::FIFO_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PW'(1);
    end
    return n;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  `FSIF_NEVER(a_no_overflow, push_i && full_o, "fifo push while full")
  `FSIF_NEVER(a_no_underflow, pop_i && !valid_o, "fifo pop while empty")
  `FSIF_ASSERT(a_count_up, (push_i && !pop_i) |=> (count_q == $past(count_q) + CW'(1)),
               "fifo count did not follow a push")

endmodule

// ===== hdl/fsif_back.sv =====
// Digit engine: converts queued commands to characters through a BCD
// converter, a digit store and an output register. Depends on fsif_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fsif_back #(
  parameter int unsigned DIGIT_DEPTH = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  fsif_pkg::cmd_t  cmd_i,
  output logic            cmd_pop_o,
  output logic            out_valid_o,
  output logic [7:0]      out_char_o,
  output logic            out_last_o,
  input  logic            out_ready_i
);

  localparam int unsigned AW = $clog2(DIGIT_DEPTH);
  localparam int unsigned CW = $clog2(DIGIT_DEPTH + 1);
  localparam int unsigned BW = fsif_pkg::BCD_W;

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_CONV  = 6'b000010,
    B_SPLIT = 6'b000100,
    B_SIGN  = 6'b001000,
    B_READ  = 6'b010000,
    B_SEND  = 6'b100000
  } back_state_e;

  back_state_e     state_q, state_d;
  logic [63:0]     bin_q, bin_d;
  logic [BW-1:0]   val_q, val_d;
  logic [5:0]      iter_q, iter_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  fsif_pkg::radix_e radix_q, radix_d;
  logic            neg_q, neg_d;

  logic            out_valid_q;
  logic [7:0]      out_char_q;
  logic            out_last_q;
  logic            out_load;
  logic [7:0]      out_char_d;
  logic            out_last_d;
  logic            out_free;

  logic [7:0]      store_q [DIGIT_DEPTH];
  logic [7:0]      rd_data_q;
  logic            wr_en;
  logic [7:0]      wr_char;
  logic            rd_en;
  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   cnt_p1;
  logic [BW-1:0]   adj;
  logic [BW-1:0]   val_shr;
  logic [3:0]      digit;

  assign out_free = !out_valid_q || out_ready_i;
  assign cnt_m1   = cnt_q - CW'(1);
  assign cnt_p1   = cnt_q + CW'(1);

  // Add-3 correction on every BCD digit before the shift.
  always_comb begin
    for (int i = 0; i < int'(fsif_pkg::BCD_DIGITS); i++) begin
      adj[i*4 +: 4] = (val_q[i*4 +: 4] >= 4'd5) ? (val_q[i*4 +: 4] + 4'd3) : val_q[i*4 +: 4];
    end
  end

  // Low digit and remaining value for the current radix.
  always_comb begin
    case (radix_q)
      fsif_pkg::RAD_OCT: begin
        digit   = {1'b0, val_q[2:0]};
        val_shr = val_q >> 3;
      end
      fsif_pkg::RAD_BIN: begin
        digit   = {3'b000, val_q[0]};
        val_shr = val_q >> 1;
      end
      default: begin
        digit   = val_q[3:0];
        val_shr = val_q >> 4;
      end
    endcase
  end

  assign wr_char = fsif_pkg::digit_char(digit);

  always_comb begin
    state_d    = state_q;
    bin_d      = bin_q;
    val_d      = val_q;
    iter_d     = iter_q;
    cnt_d      = cnt_q;
    radix_d    = radix_q;
    neg_d      = neg_q;
    cmd_pop_o  = 1'b0;
    out_load   = 1'b0;
    out_char_d = rd_data_q;
    out_last_d = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == fsif_pkg::CMD_CHAR) begin
            if (out_free) begin
              cmd_pop_o  = 1'b1;
              out_load   = 1'b1;
              out_char_d = cmd_i.ch;
              out_last_d = 1'b1;
            end
          end else begin
            cmd_pop_o = 1'b1;
            radix_d   = cmd_i.radix;
            neg_d     = cmd_i.neg;
            cnt_d     = '0;
            if (cmd_i.radix == fsif_pkg::RAD_DEC) begin
              bin_d   = cmd_i.wide ? cmd_i.mag : {cmd_i.mag[31:0], 32'd0};
              iter_d  = cmd_i.wide ? 6'd63 : 6'd31;
              val_d   = '0;
              state_d = B_CONV;
            end else begin
              val_d   = {{(BW - 64){1'b0}}, cmd_i.mag};
              state_d = B_SPLIT;
            end
          end
        end
      end
      B_CONV: begin
        val_d  = {adj[BW-2:0], bin_q[63]};
        bin_d  = {bin_q[62:0], 1'b0};
        iter_d = iter_q - 6'd1;
        if (iter_q == 6'd0) begin
          state_d = B_SPLIT;
        end
      end
      B_SPLIT: begin
        wr_en = 1'b1;
        val_d = val_shr;
        cnt_d = cnt_p1;
        if ((val_shr == '0) || (cnt_p1 == CW'(DIGIT_DEPTH))) begin
          state_d = neg_q ? B_SIGN : B_READ;
        end
      end
      B_SIGN: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_char_d = fsif_pkg::CH_MINUS;
          state_d    = B_READ;
        end
      end
      B_READ: begin
        rd_en   = 1'b1;
        state_d = B_SEND;
      end
      B_SEND: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_d = (cnt_q == CW'(1));
          cnt_d      = cnt_m1;
          state_d    = (cnt_q == CW'(1)) ? B_IDLE : B_READ;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // Digit store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[cnt_q[AW-1:0]] <= wr_char;
    end
    if (rd_en) begin
      rd_data_q <= store_q[cnt_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q   <= bin_d;
    val_q   <= val_d;
    iter_q  <= iter_d;
    radix_q <= radix_d;
    neg_q   <= neg_d;
    if (out_load) begin
      out_char_q <= out_char_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  `FSIF_NEVER(a_send_has_digit, (state_q == B_SEND) && (cnt_q == '0),
              "digit read with empty store")
  `FSIF_NEVER(a_no_overwrite, out_load && out_valid_q && !out_ready_i,
              "output register overwritten while held")
  `FSIF_ASSERT(a_split_bounded, (state_q == B_SPLIT) |-> (cnt_q < CW'(DIGIT_DEPTH)),
               "digit count ran past the store depth")

endmodule

// ===== hdl/format_string_integer_formatter_unit.sv =====
// Top level of the integer formatter: parser, command queue and digit engine.
// Depends on fsif_pkg, fsif_front, fsif_fifo and fsif_back.
`timescale 1ns / 1ps

// Channel   Direction  tdata                                  tlast     tuser
// s_axis    in         [7:0] fmt_char, [71:8] arg_value       -         -
// m_axis    out        [7:0] out_char                         out_last  -
//
// A plain character is queued as a command and then loaded into the output register.
// A decimal number first goes through the shift-and-add-3 BCD converter, which shifts
// in 64 bits (ll) or 32 bits (shorter lengths); every number then goes through the digit
// splitter at one digit per cycle, and its characters leave behind an optional sign,
// each digit through the registered digit store read. Reset is asynchronous and active
// low; the store needs no clearing. The parser runs ahead through a two-entry command
// queue, so length letters and plain text are taken while a number is still converting;
// a stalled m_axis holds the output register, the digit engine wherever it waits to load
// it and, once the queue fills, s_axis_tready.

module format_string_integer_formatter_unit #(
  parameter int unsigned DIGIT_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [7:0] fmt_char, [71:8] arg_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_char
  output logic        m_axis_tlast    // out_last
);

  logic           accept;
  logic           push;
  logic           full;
  logic           pop;
  logic           cmd_valid;
  fsif_pkg::cmd_t push_cmd;
  fsif_pkg::cmd_t cmd;

  // The parser takes an item whenever the queue has room for its command.
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid & s_axis_tready;

  fsif_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .fmt_char_i  (s_axis_tdata[7:0]),
    .arg_value_i (s_axis_tdata[71:8]),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  fsif_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (cmd_valid),
    .data_o      (cmd)
  );

  // The engine drives m_axis straight from its output register.
  fsif_back #(
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

endmodule

// ===== verif/format_string_integer_formatter_unit_tb.sv =====
// Self-checking testbench for format_string_integer_formatter_unit.
// A local predictor of the format engine feeds a queue of expected characters.
// Depends on fsif_pkg and the formatter RTL only.
`timescale 1ns / 1ps

module format_string_integer_formatter_unit_tb;

  localparam int unsigned DIGIT_DEPTH = 64;
  localparam int unsigned RANDOM_ITEMS = 294;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TAIL_CYCLES = 400;
  localparam int unsigned HOLD_AT = 60;
  localparam int unsigned HOLD_CYCLES = 600;

  localparam logic [7:0] CH_LOW_S = 8'h73;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam string DIGIT_TEXT = "0123456789abcdef";

  localparam int unsigned RADIX_DEC = 10;
  localparam int unsigned RADIX_HEX = 16;
  localparam int unsigned RADIX_OCT = 8;
  localparam int unsigned RADIX_BIN = 2;

  typedef enum logic [2:0] {
    PH_TEXT    = 3'd0,
    PH_PERCENT = 3'd1,
    PH_AFTER_H = 3'd2,
    PH_AFTER_L = 3'd3,
    PH_LETTER  = 3'd4
  } spec_phase_e;

  typedef enum logic [2:0] {
    LEN_DEFAULT = 3'd0,
    LEN_HH      = 3'd1,
    LEN_H       = 3'd2,
    LEN_L       = 3'd3,
    LEN_LL      = 3'd4
  } len_mode_e;

  typedef struct {
    logic [7:0]  ch;
    logic [63:0] arg;
    bit          drain_first;  // hold this item back until no result is pending
  } fmt_item_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } out_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  fmt_item_t   fmt_items[$];
  out_item_t   expected_chars[$];
  logic [7:0]  step_chars[$];

  spec_phase_e spec_phase;
  len_mode_e   len_mode;

  int unsigned stim_total;
  int unsigned in_count;
  int unsigned error_count;
  int unsigned cycle_count;
  bit          in_taken;
  int unsigned hold_left;
  bit          hold_done;

  format_string_integer_formatter_unit #(
    .DIGIT_DEPTH(DIGIT_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor of the format engine.
  // ---------------------------------------------------------------------------

  // Magnitude by the active length, digits least significant first into a
  // bounded store, then emitted most significant first behind an optional sign.
  function automatic void push_number(logic [63:0] arg, bit is_signed,
                                      int unsigned radix);
    logic [63:0] mag;
    bit          neg;
    logic [7:0]  digits[$];
    neg = 1'b0;
    if (len_mode == LEN_LL) begin
      mag = arg;
      if (is_signed && arg[63]) begin
        neg = 1'b1;
        mag = 64'd0 - arg;
      end
    end else begin
      mag = {32'd0, arg[31:0]};
      if (is_signed && arg[31]) begin
        neg = 1'b1;
        mag = 64'h1_0000_0000 - mag;
      end
    end
    do begin
      digits.push_front(DIGIT_TEXT[int'(mag % radix)]);
      mag = mag / radix;
    end while (mag != 0 && digits.size() < DIGIT_DEPTH);
    if (neg) begin
      step_chars.push_back(fsif_pkg::CH_MINUS);
    end
    foreach (digits[k]) begin
      step_chars.push_back(digits[k]);
    end
  endfunction

  // A letter in the conversion position always closes the spec.
  function automatic void apply_conversion(logic [7:0] ch, logic [63:0] arg);
    case (ch)
      fsif_pkg::CH_LOW_C: step_chars.push_back(arg[7:0]);
      fsif_pkg::CH_LOW_D, fsif_pkg::CH_LOW_I: push_number(arg, 1'b1, RADIX_DEC);
      fsif_pkg::CH_LOW_U: push_number(arg, 1'b0, RADIX_DEC);
      fsif_pkg::CH_LOW_X, fsif_pkg::CH_UP_X, fsif_pkg::CH_LOW_P:
        push_number(arg, 1'b0, RADIX_HEX);
      fsif_pkg::CH_LOW_O: push_number(arg, 1'b0, RADIX_OCT);
      fsif_pkg::CH_LOW_B, fsif_pkg::CH_UP_B: push_number(arg, 1'b0, RADIX_BIN);
      fsif_pkg::CH_PERCENT: step_chars.push_back(fsif_pkg::CH_PERCENT);
      default: ;  // unknown letter: nothing is emitted
    endcase
    spec_phase = PH_TEXT;
    len_mode = LEN_DEFAULT;
  endfunction

  function automatic void format_step(logic [7:0] ch, logic [63:0] arg);
    step_chars.delete();
    case (spec_phase)
      PH_PERCENT: begin
        if (ch == fsif_pkg::CH_LOW_H) begin
          len_mode = LEN_H;
          spec_phase = PH_AFTER_H;
        end else if (ch == fsif_pkg::CH_LOW_L) begin
          len_mode = LEN_L;
          spec_phase = PH_AFTER_L;
        end else begin
          apply_conversion(ch, arg);
        end
      end
      PH_AFTER_H: begin
        if (ch == fsif_pkg::CH_LOW_H) begin
          len_mode = LEN_HH;
          spec_phase = PH_LETTER;
        end else begin
          apply_conversion(ch, arg);
        end
      end
      PH_AFTER_L: begin
        if (ch == fsif_pkg::CH_LOW_L) begin
          len_mode = LEN_LL;
          spec_phase = PH_LETTER;
        end else begin
          apply_conversion(ch, arg);
        end
      end
      PH_LETTER: begin
        apply_conversion(ch, arg);
      end
      default: begin
        if (ch == fsif_pkg::CH_PERCENT) begin
          spec_phase = PH_PERCENT;
          len_mode = LEN_DEFAULT;
        end else begin
          spec_phase = PH_TEXT;
          step_chars.push_back(ch);
        end
      end
    endcase
    foreach (step_chars[k]) begin
      expected_chars.push_back('{ch: step_chars[k], last: (k == step_chars.size() - 1)});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building.
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rand_arg();
    logic [63:0] corners[7];
    logic [31:0] word;
    logic [63:0] value;
    corners = '{64'd0, '1, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
                64'h0000_0000_8000_0000, 64'h0000_0000_7fff_ffff, 64'h0000_0000_ffff_ffff};
    word = $urandom;
    case ($urandom_range(4))
      0: value = {$urandom, $urandom};
      1: value = 64'($urandom_range(0, 9999));
      2: value = corners[$urandom_range(6)];
      3: value = {{32{word[31]}}, word};
      default: value = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
    endcase
    return value;
  endfunction

  task automatic add_item(logic [7:0] ch, logic [63:0] arg, bit drain_first = 1'b0);
    fmt_items.push_back('{ch: ch, arg: arg, drain_first: drain_first});
  endtask

  task automatic add_spec(len_mode_e len, logic [7:0] letter, logic [63:0] arg,
                          bit drain_first = 1'b0);
    add_item(fsif_pkg::CH_PERCENT, rand_arg(), drain_first);
    case (len)
      LEN_HH: begin
        add_item(fsif_pkg::CH_LOW_H, rand_arg());
        add_item(fsif_pkg::CH_LOW_H, rand_arg());
      end
      LEN_H:  add_item(fsif_pkg::CH_LOW_H, rand_arg());
      LEN_L:  add_item(fsif_pkg::CH_LOW_L, rand_arg());
      LEN_LL: begin
        add_item(fsif_pkg::CH_LOW_L, rand_arg());
        add_item(fsif_pkg::CH_LOW_L, rand_arg());
      end
      default: ;
    endcase
    add_item(letter, arg);
  endtask

  // ---------------------------------------------------------------------------
  // Idling schedule: sender light and receiver heavy, then swapped, then none.
  // ---------------------------------------------------------------------------

  function automatic int unsigned sender_idle_pct();
    case ((in_count * 3) / stim_total)
      0:       return 18;
      1:       return 57;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_idle_pct();
    case ((in_count * 3) / stim_total)
      0:       return 57;
      1:       return 18;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: moves to the next item only once the current one was taken.
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (fmt_items.size() != 0 &&
            (!fmt_items[0].drain_first || expected_chars.size() == 0) &&
            $urandom_range(99) >= sender_idle_pct()) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {fmt_items[0].arg, fmt_items[0].ch};
          void'(fmt_items.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && in_count >= HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each accepted item and checks each emitted character.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    out_item_t want;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_taken = 1'b1;
        format_step(s_axis_tdata[7:0], s_axis_tdata[71:8]);
        in_count++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual char %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata !== want.ch) begin
            $display("%0t: out_char mismatch: expected %h, actual %h",
                     $time, want.ch, m_axis_tdata);
            error_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: out_last mismatch: expected %b, actual %b",
                     $time, want.last, m_axis_tlast);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------

  initial begin
    logic [7:0] letters[12];
    int unsigned pick;
    int unsigned random_start;
    int unsigned random_end;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    rst_ni = 1'b0;
    spec_phase = PH_TEXT;
    len_mode = LEN_DEFAULT;
    in_count = 0;
    error_count = 0;
    cycle_count = 0;
    hold_left = 0;
    hold_done = 1'b0;
    letters = '{fsif_pkg::CH_LOW_C, fsif_pkg::CH_LOW_D, fsif_pkg::CH_LOW_I,
                fsif_pkg::CH_LOW_U, fsif_pkg::CH_LOW_X, fsif_pkg::CH_UP_X,
                fsif_pkg::CH_LOW_P, fsif_pkg::CH_LOW_O, fsif_pkg::CH_LOW_B,
                fsif_pkg::CH_UP_B, fsif_pkg::CH_PERCENT, CH_LOW_S};

    // Directed part: character extremes, every conversion, both most negative
    // values, the longest binary string and an unknown letter.
    add_item(CH_NUL, '1);
    add_spec(LEN_DEFAULT, fsif_pkg::CH_LOW_C, 64'h0000_0000_0000_00ff);
    add_spec(LEN_LL, fsif_pkg::CH_LOW_D, 64'h8000_0000_0000_0000);
    add_spec(LEN_DEFAULT, fsif_pkg::CH_LOW_D, 64'hffff_ffff_8000_0000);
    add_spec(LEN_DEFAULT, fsif_pkg::CH_LOW_I, 64'd0);
    add_spec(LEN_H, fsif_pkg::CH_LOW_U, '1);
    add_spec(LEN_DEFAULT, fsif_pkg::CH_LOW_X, 64'h1234_5678_9abc_def0);
    add_spec(LEN_DEFAULT, fsif_pkg::CH_UP_X, 64'h0000_0000_dead_beef);
    add_spec(LEN_L, fsif_pkg::CH_LOW_P, 64'h0000_0000_0000_00a5);
    add_spec(LEN_HH, fsif_pkg::CH_LOW_O, '1);
    add_spec(LEN_LL, fsif_pkg::CH_LOW_B, '1);
    add_spec(LEN_DEFAULT, fsif_pkg::CH_UP_B, 64'h0000_0000_0000_0005);
    add_spec(LEN_DEFAULT, fsif_pkg::CH_PERCENT, 64'd0);
    add_spec(LEN_L, CH_LOW_S, 64'd42);

    // Random part: mostly well-formed specs, some plain text and broken specs.
    random_start = fmt_items.size();
    random_end = random_start + RANDOM_ITEMS;
    while (fmt_items.size() < random_end) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        add_item(8'($urandom_range(255)), rand_arg());
      end else if (pick < 88) begin
        add_spec(len_mode_e'($urandom_range(4)), letters[$urandom_range(11)], rand_arg(),
                 (fmt_items.size() + 40 == random_end));
      end else begin
        add_item(fsif_pkg::CH_PERCENT, rand_arg());
        if ($urandom_range(1)) begin
          add_item($urandom_range(1) ? fsif_pkg::CH_LOW_H : fsif_pkg::CH_LOW_L, rand_arg());
        end
        add_item(8'($urandom_range(255)), rand_arg());
      end
    end
    stim_total = fmt_items.size();
    // The first random item also waits for the directed output to drain.
    fmt_items[random_start].drain_first = 1'b1;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (in_count != stim_total) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
